### hdl/twrpf_pkg.sv
// Shared types and constants of the two-way ranging responder framer.
package twrpf_pkg;

    // Input event selector (tuser of the input stream)
    typedef enum logic [1:0] {
        FUNC_RX_BYTE   = 2'd0,
        FUNC_FRAME_END = 2'd1,
        FUNC_RX_ERROR  = 2'd2,
        FUNC_TX_DONE   = 2'd3
    } func_t;

    // Result kind (tuser of the output stream)
    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_REJECT = 1'b1
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_OWN_ADDR    = 2'd0,
        CFG_REPLY_DELAY = 2'd1,
        CFG_ANT_DELAY   = 2'd2
    } cfg_index_t;

    // Frame bytes
    localparam logic [7:0] FRAME_CTRL_LO = 8'h41;
    localparam logic [7:0] FRAME_CTRL_HI = 8'h88;
    localparam logic [7:0] PAN_ID_LO     = 8'hCA;
    localparam logic [7:0] PAN_ID_HI     = 8'hDE;
    localparam logic [7:0] CODE_POLL     = 8'hE0;
    localparam logic [7:0] CODE_RESP     = 8'hE1;

    // Poll byte positions
    localparam int unsigned POS_FC_LO    = 0;
    localparam int unsigned POS_FC_HI    = 1;
    localparam int unsigned POS_PAN_LO   = 3;
    localparam int unsigned POS_PAN_HI   = 4;
    localparam int unsigned POS_DST_LO   = 5;
    localparam int unsigned POS_DST_HI   = 6;
    localparam int unsigned POS_SRC_LO   = 7;
    localparam int unsigned POS_SRC_HI   = 8;
    localparam int unsigned POS_CODE     = 9;
    localparam int unsigned POLL_MIN_LEN = 10;

    // Response frame
    localparam int unsigned RESP_LEN = 18;
    localparam int unsigned IDX_W    = 5;

    // Reset values of the configuration registers
    localparam logic [15:0] OWN_ADDR_RST    = 16'd16962;
    localparam logic [31:0] REPLY_DELAY_RST = 32'd28754100;
    localparam logic [15:0] ANT_DELAY_RST   = 16'd16385;

    // One checked frame end, handed to the response emitter
    typedef struct packed {
        logic        reject;
        logic [7:0]  seq;
        logic [7:0]  src_lo;
        logic [7:0]  src_hi;
        logic [31:0] ts1;
        logic [31:0] ts2;
        logic [31:0] word;
    } job_t;

endpackage

### hdl/twr_poll_responder_framer.sv
// Top level of the two-way ranging responder framer: poll store, checks, response timing.
//
//  channel | direction | signals                               | contents
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser     | poll bytes and receiver events
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser ... | response bytes or reject marks
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data| own address, reply and antenna delay
//
// Received bytes, receive errors and transmit-done events are taken whenever s_tready is high.
// A frame end holds s_tready low while it passes two paired reads of the poll RAM and then
// the job slot, and longer while the previous response is still being emitted.
// A response leaves as 18 transfers, one per cycle while m_tready is high; a reject as one.
// Reset is synchronous; the poll RAM needs no clearing pass. Output stalls back up into
// the job slot and from there into s_tready. The output goes idle between responses.
module twr_poll_responder_framer
    import twrpf_pkg::*;
#(
    parameter int RX_STORE_DEPTH = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rx_byte[7:0], rx_timestamp[47:8]
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_byte[7:0], byte_index[12:8], tx_start_word[44:13]
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(RX_STORE_DEPTH);
    localparam int CW = $clog2(RX_STORE_DEPTH + 2);

    // configuration
    logic [15:0] own_reg;
    logic [31:0] delay_reg;
    logic [15:0] antdly_reg;

    // receive state
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    seq_reg, seq_next;
    logic          hdr_bad_reg;

    // frame-end pipeline
    logic          c1_valid_reg;
    logic [39:0]   c1_ts_reg;
    logic [7:0]    c1_seq_reg;
    logic          c1_pre_ok_reg;
    logic          c2_valid_reg;
    logic          c2_ok_reg;
    logic [31:0]   c2_word_reg;
    logic [31:0]   c2_ts1_reg;
    logic [7:0]    c2_seq_reg;
    logic          job_valid_reg;
    job_t          job_reg;
    logic          job_take;

    // input decode
    logic          s_accept;
    func_t         func;
    logic [7:0]    rx_byte;
    logic [39:0]   rx_ts;
    logic          room;
    logic          len_ok;
    logic          hdr_mismatch;

    // poll RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [7:0]    rdata_a, rdata_b;

    logic [39:0]   delay_sum;
    logic          addr_ok;
    logic [31:0]   ts2;

    assign s_tready  = !(c1_valid_reg || c2_valid_reg || job_valid_reg);
    assign s_accept  = s_tvalid && s_tready;
    assign func      = func_t'(s_tuser);
    assign rx_byte   = s_tdata[7:0];
    assign rx_ts     = s_tdata[47:8];
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg    <= OWN_ADDR_RST;
            delay_reg  <= REPLY_DELAY_RST;
            antdly_reg <= ANT_DELAY_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OWN_ADDR:    own_reg    <= cfg_data[15:0];
                CFG_REPLY_DELAY: delay_reg  <= cfg_data;
                CFG_ANT_DELAY:   antdly_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // byte store and counting
    assign room      = count_reg < CW'(RX_STORE_DEPTH);
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_we    = s_accept && (func == FUNC_RX_BYTE) && room;

    // fixed header bytes are checked as they arrive
    always_comb begin
        unique case (ram_waddr)
            AW'(POS_FC_LO):  hdr_mismatch = rx_byte != FRAME_CTRL_LO;
            AW'(POS_FC_HI):  hdr_mismatch = rx_byte != FRAME_CTRL_HI;
            AW'(POS_PAN_LO): hdr_mismatch = rx_byte != PAN_ID_LO;
            AW'(POS_PAN_HI): hdr_mismatch = rx_byte != PAN_ID_HI;
            AW'(POS_CODE):   hdr_mismatch = rx_byte != CODE_POLL;
            default:         hdr_mismatch = 1'b0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        seq_next   = seq_reg;
        if (s_accept) begin
            unique case (func)
                FUNC_RX_BYTE:   count_next = room ? count_reg + CW'(1)
                                                  : CW'(RX_STORE_DEPTH + 1);
                FUNC_FRAME_END: count_next = '0;
                FUNC_RX_ERROR:  count_next = '0;
                FUNC_TX_DONE:   seq_next   = seq_reg + 8'd1;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            seq_reg     <= '0;
            hdr_bad_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            seq_reg   <= seq_next;
            if (s_accept && (func == FUNC_FRAME_END || func == FUNC_RX_ERROR)) begin
                hdr_bad_reg <= 1'b0;
            end else if (ram_we && hdr_mismatch) begin
                hdr_bad_reg <= 1'b1;
            end
        end
    end

    assign len_ok = (count_reg >= CW'(POLL_MIN_LEN)) && (count_reg <= CW'(RX_STORE_DEPTH));

    // destination address on the first read, sender address on the second
    assign raddr_a = c1_valid_reg ? AW'(POS_SRC_LO) : AW'(POS_DST_LO);
    assign raddr_b = c1_valid_reg ? AW'(POS_SRC_HI) : AW'(POS_DST_HI);

    twrpf_ram #(
        .WIDTH (8),
        .DEPTH (RX_STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (rx_byte),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // stage 1: capture the frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
        end else begin
            c1_valid_reg <= s_accept && (func == FUNC_FRAME_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && func == FUNC_FRAME_END) begin
            c1_ts_reg     <= rx_ts;
            c1_seq_reg    <= seq_reg;
            c1_pre_ok_reg <= len_ok && !hdr_bad_reg;
        end
    end

    // stage 2: address compare and delayed transmit word
    assign addr_ok   = (rdata_a == own_reg[7:0]) && (rdata_b == own_reg[15:8]);
    assign delay_sum = c1_ts_reg + {8'h00, delay_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_valid_reg <= 1'b0;
        end else begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c1_valid_reg) begin
            c2_ok_reg   <= c1_pre_ok_reg && addr_ok;
            c2_word_reg <= delay_sum[39:8];
            c2_ts1_reg  <= c1_ts_reg[31:0];
            c2_seq_reg  <= c1_seq_reg;
        end
    end

    // stage 3: announced timestamp and job slot
    assign ts2 = {c2_word_reg[23:1], 9'h000} + {16'h0000, antdly_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (c2_valid_reg) begin
            job_valid_reg <= 1'b1;
        end else if (job_take) begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c2_valid_reg) begin
            job_reg.reject <= !c2_ok_reg;
            job_reg.seq    <= c2_seq_reg;
            job_reg.src_lo <= rdata_a;
            job_reg.src_hi <= rdata_b;
            job_reg.ts1    <= c2_ts1_reg;
            job_reg.ts2    <= ts2;
            job_reg.word   <= c2_word_reg;
        end
    end

    twrpf_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid_reg),
        .job         (job_reg),
        .job_take    (job_take),
        .own_address (own_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // count never runs past the overflow mark
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RX_STORE_DEPTH + 1))
        else $error("byte count out of range");

    // no store write while the address reads are in flight
    a_no_write_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (c1_valid_reg || c2_valid_reg) |-> !ram_we)
        else $error("poll store written during frame-end reads");

    // a frame end passes stage 1 and reaches stage 2 while the job slot is still empty
    a_frame_end_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && func == FUNC_FRAME_END) |=> ##1 (c2_valid_reg && !job_valid_reg))
        else $error("frame end lost in check pipeline");

    // transmit-done advances the sequence number by one
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && func == FUNC_TX_DONE) |=> (seq_reg == $past(seq_reg) + 8'd1))
        else $error("sequence number did not advance");

endmodule

### hdl/twrpf_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module twrpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hdl/twrpf_emit.sv
// Response emitter: walks one checked job out as byte transfers, or as one reject mark, through an output register.
module twrpf_emit
    import twrpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    input  logic [15:0] own_address,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_byte[7:0], byte_index[12:8], tx_start_word[44:13]
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RESP_LEN - 1);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    job_t             cur_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_last_reg;
    logic [31:0]      out_word_reg;

    logic             out_free;
    logic             load;
    logic             at_end;
    logic [7:0]       byte_sel;

    assign out_free = !out_valid_reg || m_tready;
    assign load     = busy_reg && out_free;
    assign job_take = job_valid && !busy_reg;
    assign at_end   = cur_reg.reject || (idx_reg == LAST_IDX);

    // response byte for the current position
    always_comb begin
        unique case (idx_reg)
            5'd0:    byte_sel = FRAME_CTRL_LO;
            5'd1:    byte_sel = FRAME_CTRL_HI;
            5'd2:    byte_sel = cur_reg.seq;
            5'd3:    byte_sel = PAN_ID_LO;
            5'd4:    byte_sel = PAN_ID_HI;
            5'd5:    byte_sel = cur_reg.src_lo;
            5'd6:    byte_sel = cur_reg.src_hi;
            5'd7:    byte_sel = own_address[7:0];
            5'd8:    byte_sel = own_address[15:8];
            5'd9:    byte_sel = CODE_RESP;
            5'd10:   byte_sel = cur_reg.ts1[7:0];
            5'd11:   byte_sel = cur_reg.ts1[15:8];
            5'd12:   byte_sel = cur_reg.ts1[23:16];
            5'd13:   byte_sel = cur_reg.ts1[31:24];
            5'd14:   byte_sel = cur_reg.ts2[7:0];
            5'd15:   byte_sel = cur_reg.ts2[15:8];
            5'd16:   byte_sel = cur_reg.ts2[23:16];
            5'd17:   byte_sel = cur_reg.ts2[31:24];
            default: byte_sel = 8'h00;
        endcase
    end

    // job walker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (job_take) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= !at_end;
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (job_take) begin
            cur_reg <= job;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (cur_reg.reject) begin
                out_kind_reg <= KIND_REJECT;
                out_byte_reg <= 8'h00;
                out_idx_reg  <= '0;
                out_last_reg <= 1'b1;
                out_word_reg <= 32'h0;
            end else begin
                out_kind_reg <= KIND_BYTE;
                out_byte_reg <= byte_sel;
                out_idx_reg  <= idx_reg;
                out_last_reg <= at_end;
                out_word_reg <= cur_reg.word;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_word_reg, out_idx_reg, out_byte_reg};

endmodule
